[src/fsp_pkg.sv]
// shared constants and codes for the scrambled fsk pulse shaper
// no dependencies; imported by every module of the block
package fsp_pkg;

   localparam int PHASES_DEF = 32;
   localparam int TAPS_DEF   = 8;

   localparam int COEF_W  = 16;
   localparam int PHASE_W = 16;
   localparam int SCR_W   = 19;

   localparam logic [PHASE_W-1:0] STEP_RESET = 16'd43690;
   localparam logic [PHASE_W-1:0] MIN_STEP   = 16'd4096;

   // item command codes
   localparam logic CMD_COEF = 1'b0;
   localparam logic CMD_XMIT = 1'b1;

endpackage

[src/fsp_coef_mem.sv]
// coefficient store: one row of taps per polyphase set, per-tap write enable
// registered row read; depends on fsp_pkg
module fsp_coef_mem
   import fsp_pkg::*;
#(
   parameter int PHASES = PHASES_DEF,
   parameter int TAPS   = TAPS_DEF,
   localparam int SET_W = $clog2(PHASES),
   localparam int TAP_W = $clog2(TAPS)
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [SET_W-1:0]               wr_set,
   input  logic [TAP_W-1:0]               wr_tap,
   input  logic [COEF_W-1:0]              wr_value,
   input  logic                           rd_en,
   input  logic [SET_W-1:0]               rd_set,
   output logic [TAPS-1:0][COEF_W-1:0]    rd_row
);

   logic [TAPS-1:0][COEF_W-1:0] mem [PHASES];
   logic [TAPS-1:0][COEF_W-1:0] rd_row_ff;

   // single coefficient write into its tap lane
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_set][wr_tap] <= wr_value;
      end
   end

   // row read, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_set];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

[src/fsp_phase_gen.sv]
// sample phase accumulator, scrambler and bit history
// gives the polyphase set of the next sample; depends on fsp_pkg
module fsp_phase_gen
   import fsp_pkg::*;
#(
   parameter int PHASES = PHASES_DEF,
   parameter int TAPS   = TAPS_DEF,
   localparam int SET_W = $clog2(PHASES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [PHASE_W-1:0] step,
   input  logic               data_bit,
   output logic [SET_W-1:0]   rd_set,
   output logic [TAPS-1:0]    history,
   output logic               done
);

   localparam int PROD_W = PHASE_W + SET_W;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SCR_W-1:0]   scr_ff, scr_in;
   logic [TAPS-1:0]    hist_ff, hist_in;
   logic               done_ff, done_in;
   logic [PHASE_W:0]   phase_sum;
   logic [SCR_W-1:0]   scr_shift;
   logic [PROD_W-1:0]  set_prod;

   // next phase and wrap
   assign phase_sum = {1'b0, phase_ff} + {1'b0, step};

   // set = (phase * PHASES) >> 16
   assign set_prod = PROD_W'(phase_sum[PHASE_W-1:0]) * PROD_W'(PHASES);
   assign rd_set   = set_prod[PROD_W-1:PHASE_W];

   // scrambler step with inverted data bit, bits 6 and 1 flipped when bit 18 is set
   always_comb begin
      scr_shift = {scr_ff[SCR_W-2:0], scr_ff[0] ^ data_bit ^ 1'b1};
      if (scr_shift[SCR_W-1]) begin
         scr_shift = scr_shift ^ SCR_W'(7'b1000010);
      end
   end

   // state update per sample, bit consumed at the wrap
   always_comb begin
      phase_in = phase_ff;
      scr_in   = scr_ff;
      hist_in  = hist_ff;
      done_in  = done_ff;
      if (step_en) begin
         phase_in = phase_sum[PHASE_W-1:0];
         done_in  = phase_sum[PHASE_W];
         if (phase_sum[PHASE_W]) begin
            scr_in  = scr_shift;
            hist_in = {hist_ff[TAPS-2:0], scr_shift[17]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         scr_ff   <= '0;
         hist_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         scr_ff   <= scr_in;
         hist_ff  <= hist_in;
         done_ff  <= done_in;
      end
   end

   assign history = hist_ff;
   assign done    = done_ff;

endmodule

[src/fsp_tap_sum.sv]
// signed tap sum: add a tap for a history one, subtract it for a zero
// result wraps to 16 bits; depends on fsp_pkg
module fsp_tap_sum
   import fsp_pkg::*;
#(
   parameter int TAPS = TAPS_DEF
) (
   input  logic [TAPS-1:0][COEF_W-1:0] row,
   input  logic [TAPS-1:0]             history,
   output logic [COEF_W-1:0]           sum
);

   always_comb begin
      logic [COEF_W-1:0] acc;
      acc = '0;
      for (int t = 0; t < TAPS; t++) begin
         if (history[t]) begin
            acc = acc + row[t];
         end else begin
            acc = acc - row[t];
         end
      end
      sum = acc;
   end

endmodule

[src/scrambled_fsk_pulse_shaper_unit.sv]
// scrambled fsk pulse shaper: top level with control sequencer and output register
// coefficient write item: does not take the block out of idle; data item: n samples (n <= 16)
// each sample steps the phase and reads the row, then forms the tap sum; an output stall holds the sum
// the first sample passes the step and sum states and is then held in the output register
// synchronous active-high reset clears phase, scrambler and history and sets step to 43690;
// the coefficient store is not cleared and must be loaded before use
module scrambled_fsk_pulse_shaper_unit
   import fsp_pkg::*;
#(
   parameter int PHASES = PHASES_DEF,
   parameter int TAPS   = TAPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic                     req_data_bit,
   input  logic [4:0]               req_coef_phase,
   input  logic [2:0]               req_coef_tap,
   input  logic signed [COEF_W-1:0] req_coef_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COEF_W-1:0] rsp_sample,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [PHASE_W-1:0]       csr_phase_step
);

   localparam int SET_W = $clog2(PHASES);
   localparam int TAP_W = $clog2(TAPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [PHASE_W-1:0]          step_ff;
   logic [PHASE_W-1:0]          eff_step;
   logic                        bit_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0]           rsp_sample_ff;
   logic                        rsp_last_ff;
   logic                        req_take;
   logic                        wr_en;
   logic                        step_en;
   logic                        out_load;
   logic                        out_free;
   logic [SET_W-1:0]            rd_set;
   logic [TAPS-1:0]             history;
   logic                        done;
   logic [TAPS-1:0][COEF_W-1:0] rd_row;
   logic [COEF_W-1:0]           tap_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // phase step register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         step_ff <= csr_phase_step;
      end
   end

   assign eff_step = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;

   // coefficient write, ignored outside the table
   assign wr_en = req_take && (req_command == CMD_COEF)
                  && (int'(req_coef_phase) < PHASES) && (int'(req_coef_tap) < TAPS);

   // latch the data bit of every item taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         bit_ff <= req_data_bit;
      end
   end

   // output register is free or being emptied
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: step phase and read row, then sum and hand over
   always_comb begin
      state_in = state_ff;
      step_en  = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_command == CMD_XMIT)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            step_en  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = done ? ST_IDLE : ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output item register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= tap_sum;
         rsp_last_ff   <= done;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   fsp_phase_gen #(
      .PHASES (PHASES),
      .TAPS   (TAPS)
   ) u_phase_gen (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .step     (eff_step),
      .data_bit (bit_ff),
      .rd_set   (rd_set),
      .history  (history),
      .done     (done)
   );

   fsp_coef_mem #(
      .PHASES (PHASES),
      .TAPS   (TAPS)
   ) u_coef_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_set   (SET_W'(req_coef_phase)),
      .wr_tap   (TAP_W'(req_coef_tap)),
      .wr_value (req_coef_value),
      .rd_en    (step_en),
      .rd_set   (rd_set),
      .rd_row   (rd_row)
   );

   fsp_tap_sum #(
      .TAPS (TAPS)
   ) u_tap_sum (
      .row     (rd_row),
      .history (history),
      .sum     (tap_sum)
   );

endmodule

[src/fsp_checker.sv]
// port-level checks for the scrambled fsk pulse shaper
// depends on fsp_pkg; bound to scrambled_fsk_pulse_shaper_unit below
module fsp_checker
   import fsp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_command,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [COEF_W-1:0] rsp_sample,
   input logic                     rsp_last
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("stalled result item changed");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a taken data item drops the request ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_XMIT) |=> !req_ready)
      else $error("data item did not occupy the block");

   // a coefficient write leaves the block ready for another item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_COEF) |=> req_ready)
      else $error("coefficient write stalled the block");

endmodule

bind scrambled_fsk_pulse_shaper_unit fsp_checker u_fsp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_sample  (rsp_sample),
   .rsp_last    (rsp_last)
);
